// ----- src/cor_pkg.sv -----
// shared types and constants for the controller orientation recenter block
package cor_pkg;
  localparam logic CMD_HEADSET = 1'b0;
  localparam logic CMD_SAMPLE  = 1'b1;
  localparam int   BTN_RESET   = 5;
  localparam logic [6:0] BTN_KEEP_MASK = 7'h5f;

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } alu_op_t;

  // request from the sequencer to the shared arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;
endpackage

// ----- src/controller_orientation_recenter.sv -----
// top level: controller orientation recenter with a shared mac and divider
// Usage: one input word per accepted in_valid/in_ready handshake. A word with
// cmd 0 stores the headset rotation quaternion and gives no result word. A
// word with cmd 1 works on one hand and gives one result word on out_*.
// When the reset button (bit 5) is set, the center and zero quaternions of
// that hand are recaptured first: two squared norms on the mac and eight
// divisions on a single restoring divider. Every sample then runs three
// quaternion products on one shared multiplier, each component accumulated
// term by term and then written back. One item is in flight at a time,
// in_ready is low meanwhile. The result is held in an output register; a
// stalled receiver holds it and the block takes no new word until it is taken.
// Reset (rst_n low, synchronous) sets the headset, center and zero quaternions to identity.
module controller_orientation_recenter import cor_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRAC_BITS       = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic                              in_hand,
  input  logic [6:0]                        in_buttons,
  input  logic signed [15:0]                in_touch_x,
  input  logic signed [15:0]                in_touch_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hand,
  output logic [6:0]                        out_button_flags,
  output logic                              out_pad_touched,
  output logic signed [15:0]                out_pad_x,
  output logic signed [15:0]                out_pad_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_orient_w,
  output logic signed [COMPONENT_WIDTH-1:0] out_orient_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_orient_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_orient_z
);
  localparam int CWD = COMPONENT_WIDTH;
  typedef logic signed [CWD-1:0] comp_t;
  typedef comp_t [3:0] quat_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_NRM  = 8'b0000_0010,
    ST_DIVS = 8'b0000_0100,
    ST_DIVW = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_MWR  = 8'b0010_0000,
    ST_OUT  = 8'b0100_0000,
    ST_NWR  = 8'b1000_0000
  } state_t;

  // sqrt(1/2) at FRAC_BITS, saturated
  localparam longint CRAW = (64'd3037000500 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam longint CMAXL = (64'd1 << (CWD-1)) - 1;
  localparam comp_t CCORR = comp_t'((CRAW > CMAXL) ? CMAXL : CRAW);
  localparam longint IDL = ((64'd1 << FRAC_BITS) > CMAXL) ? CMAXL : (64'd1 << FRAC_BITS);
  localparam comp_t CONE = comp_t'(IDL);

  state_t state_r, state_nxt;
  quat_t  head_r, raw_r, acc_q_r, cen_r [2], zer_r [2];
  logic   hand_r, reset_cap_r;
  logic [6:0]  btn_r;
  logic [15:0] tx_r, ty_r;
  logic [1:0]  pass_r;   // product pass: 0 fix*raw, 1 *zero, 2 *center
  logic [1:0]  comp_r;   // component index
  logic [1:0]  term_r;   // product term index
  logic        nsel_r;   // 0 headset norm, 1 raw norm
  logic [2:0]  dsel_r;   // division index
  logic [CWD+1:0] den_r [2];
  logic        out_valid_r;
  quat_t       res_r;

  // mac operand selection
  quat_t p_q, q_q;
  comp_t mac_a, mac_b;
  logic  mac_neg, mac_clr, mac_en;
  logic signed [2*CWD+2:0] mac_acc;
  comp_t mac_res;
  logic [1:0] pi, qi;

  always_comb begin
    case (pass_r)
      2'd0:    begin p_q = {comp_t'(0), comp_t'(0), CCORR, CCORR}; q_q = raw_r; end
      2'd1:    begin p_q = acc_q_r; q_q = zer_r[hand_r]; end
      default: begin p_q = acc_q_r; q_q = cen_r[hand_r]; end
    endcase
  end

  // term table of the product: q index, p index, negate
  always_comb begin
    pi = 2'd0; qi = 2'd0; mac_neg = 1'b0;
    case ({comp_r, term_r})
      4'h0: begin qi = 0; pi = 0; end
      4'h1: begin qi = 1; pi = 1; mac_neg = 1'b1; end
      4'h2: begin qi = 2; pi = 2; mac_neg = 1'b1; end
      4'h3: begin qi = 3; pi = 3; mac_neg = 1'b1; end
      4'h4: begin qi = 0; pi = 1; end
      4'h5: begin qi = 1; pi = 0; end
      4'h6: begin qi = 2; pi = 3; end
      4'h7: begin qi = 3; pi = 2; mac_neg = 1'b1; end
      4'h8: begin qi = 0; pi = 2; end
      4'h9: begin qi = 2; pi = 0; end
      4'ha: begin qi = 3; pi = 1; end
      4'hb: begin qi = 1; pi = 3; mac_neg = 1'b1; end
      4'hc: begin qi = 0; pi = 3; end
      4'hd: begin qi = 3; pi = 0; end
      4'he: begin qi = 1; pi = 2; end
      default: begin qi = 2; pi = 1; mac_neg = 1'b1; end
    endcase
    if (state_r == ST_NRM) begin
      qi = term_r; pi = term_r; mac_neg = 1'b0;
    end
  end

  assign mac_a = (state_r == ST_NRM) ? (nsel_r ? raw_r[qi] : head_r[qi]) : q_q[qi];
  assign mac_b = (state_r == ST_NRM) ? (nsel_r ? raw_r[pi] : head_r[pi]) : p_q[pi];
  assign mac_en = (state_r == ST_NRM) || (state_r == ST_MUL);
  assign mac_clr = (term_r == 2'd0);

  cor_mac #(.COMPONENT_WIDTH(CWD), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .clr(mac_clr), .acc_en(mac_en), .neg(mac_neg),
    .a(mac_a), .b(mac_b), .acc(mac_acc), .rnd_sat(mac_res)
  );

  // divider; norm stored unsaturated-positive, clipped to the divider width
  logic  div_start, div_done, div_neg;
  comp_t div_num, div_q;
  logic signed [2*CWD+2:0] nrm_rnd;
  logic [CWD+1:0] nrm_clip;
  assign nrm_rnd = (mac_acc + ((2*CWD+3)'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
  assign nrm_clip = (nrm_rnd > $signed((2*CWD+3)'({(CWD+2){1'b1}}))) ? '1 : nrm_rnd[CWD+1:0];

  assign div_start = (state_r == ST_DIVS);
  assign div_num = dsel_r[2] ? raw_r[dsel_r[1:0]] : head_r[dsel_r[1:0]];
  assign div_neg = dsel_r[2] ? (dsel_r[1:0] != 2'd0) : 1'b1;

  cor_div #(.COMPONENT_WIDTH(CWD), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(den_r[dsel_r[2]]), .negate(div_neg), .done(div_done), .quo(div_q)
  );

  // no new word while a result word waits in the output register
  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready && in_cmd == CMD_SAMPLE)
                 state_nxt = in_buttons[BTN_RESET] ? ST_NRM : ST_MUL;
      ST_NRM:  if (term_r == 2'd3) state_nxt = ST_NWR;
      ST_NWR:  state_nxt = nsel_r ? ST_DIVS : ST_NRM;
      ST_DIVS: state_nxt = ST_DIVW;
      ST_DIVW: if (div_done) state_nxt = (dsel_r == 3'd7) ? ST_MUL : ST_DIVS;
      ST_MUL:  if (term_r == 2'd3) state_nxt = ST_MWR;
      ST_MWR:  if (comp_r == 2'd3 && pass_r == 2'd2) state_nxt = ST_OUT;
               else state_nxt = ST_MUL;
      ST_OUT:  if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      head_r <= {comp_t'(0), comp_t'(0), comp_t'(0), CONE};
      for (int h = 0; h < 2; h++) begin
        cen_r[h] <= {comp_t'(0), comp_t'(0), comp_t'(0), CONE};
        zer_r[h] <= {comp_t'(0), comp_t'(0), comp_t'(0), CONE};
      end
      term_r <= '0; comp_r <= '0; pass_r <= '0; nsel_r <= 1'b0; dsel_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          term_r <= '0; comp_r <= '0; pass_r <= '0; nsel_r <= 1'b0; dsel_r <= '0;
          if (in_valid && in_ready) begin
            if (in_cmd == CMD_HEADSET)
              head_r <= {in_quat_z, in_quat_y, in_quat_x, in_quat_w};
            raw_r <= {in_quat_z, in_quat_y, in_quat_x, in_quat_w};
            hand_r <= in_hand; btn_r <= in_buttons; tx_r <= in_touch_x; ty_r <= in_touch_y;
          end
        end
        ST_NRM: term_r <= term_r + 2'd1;
        ST_NWR: begin
          den_r[nsel_r] <= nrm_clip;
          nsel_r <= 1'b1;
        end
        ST_DIVW: if (div_done) begin
          if (dsel_r[2]) zer_r[hand_r][dsel_r[1:0]] <= div_q;
          else           cen_r[hand_r][dsel_r[1:0]] <= div_q;
          dsel_r <= dsel_r + 3'd1;
        end
        ST_MUL: term_r <= term_r + 2'd1;
        ST_MWR: begin
          res_r[comp_r] <= mac_res;
          comp_r <= comp_r + 2'd1;
          if (comp_r == 2'd3) begin
            acc_q_r <= {mac_res, res_r[2], res_r[1], res_r[0]};
            pass_r <= pass_r + 2'd1;
          end
        end
        ST_OUT: if (!out_valid_r) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_hand = hand_r;
  assign out_button_flags = btn_r & BTN_KEEP_MASK;
  assign out_pad_touched = (tx_r != '0) || (ty_r != '0);
  assign out_pad_x = tx_r;
  assign out_pad_y = ty_r;
  assign out_orient_w = acc_q_r[0];
  assign out_orient_x = acc_q_r[1];
  assign out_orient_y = acc_q_r[2];
  assign out_orient_z = acc_q_r[3];

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(state_r == ST_MUL)) else $error("busy while result pending");
  a_div_only_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVS) |-> btn_r[BTN_RESET]) else $error("division without reset");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_orient_w)) else $error("result lost");
`endif
endmodule

// ----- src/cor_mac.sv -----
// shared multiply-accumulate unit: one product per cycle while acc_en is set, rounded and saturated
module cor_mac import cor_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRAC_BITS       = 14
) (
  input  logic                              clk,
  input  logic                              clr,
  input  logic                              acc_en,
  input  logic                              neg,
  input  logic signed [COMPONENT_WIDTH-1:0] a,
  input  logic signed [COMPONENT_WIDTH-1:0] b,
  output logic signed [2*COMPONENT_WIDTH+2:0] acc,
  output logic signed [COMPONENT_WIDTH-1:0] rnd_sat
);
  localparam int AW = 2*COMPONENT_WIDTH + 3;
  logic signed [2*COMPONENT_WIDTH-1:0] prod;
  logic signed [AW-1:0] acc_r, acc_nxt, rnd;
  logic signed [AW-1:0] cmax, cmin;

  assign prod = a * b;
  assign cmax = AW'((64'sd1 <<< (COMPONENT_WIDTH-1)) - 1);
  assign cmin = -cmax - AW'(1);

  always_comb begin
    acc_nxt = clr ? '0 : acc_r;
    if (acc_en) begin
      if (neg) acc_nxt = acc_nxt - AW'(prod);
      else     acc_nxt = acc_nxt + AW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round half up then saturate
  assign rnd = (acc_r + (AW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
  always_comb begin
    if (rnd > cmax)      rnd_sat = cmax[COMPONENT_WIDTH-1:0];
    else if (rnd < cmin) rnd_sat = cmin[COMPONENT_WIDTH-1:0];
    else                 rnd_sat = rnd[COMPONENT_WIDTH-1:0];
  end
  assign acc = acc_r;
endmodule

// ----- src/cor_div.sv -----
// restoring divider, one quotient bit per cycle, rounded and saturated
module cor_div import cor_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRAC_BITS       = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [COMPONENT_WIDTH-1:0] num,
  input  logic        [COMPONENT_WIDTH+1:0] den,
  input  logic                              negate,
  output logic                              done,
  output logic signed [COMPONENT_WIDTH-1:0] quo
);
  // magnitude < 2^CW; numerator scaled by 2^FB plus den/2
  localparam int NW = COMPONENT_WIDTH + FRAC_BITS + 1;
  localparam int DW = COMPONENT_WIDTH + 2;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] n_r, n_nxt;
  logic [DW:0]   rem_r, rem_nxt, trial;
  logic [NW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, neg_r, neg_nxt, zn_r, zn_nxt, zd_r, zd_nxt;
  logic          done_r, done_nxt;
  logic [COMPONENT_WIDTH:0] mag;
  logic [NW-1:0] qmax, qmin_mag;

  assign mag = num[COMPONENT_WIDTH-1] ? (COMPONENT_WIDTH+1)'(-$signed({num[COMPONENT_WIDTH-1], num}))
                                      : {1'b0, num};
  assign trial = {rem_r[DW-1:0], n_r[NW-1]} - {1'b0, den};
  assign qmax = NW'((64'd1 << (COMPONENT_WIDTH-1)) - 1);
  assign qmin_mag = NW'(64'd1 << (COMPONENT_WIDTH-1));

  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; zn_nxt = zn_r; zd_nxt = zd_r; done_nxt = 1'b0;
    if (start) begin
      n_nxt = (NW'(mag) << FRAC_BITS) + NW'(den >> 1);
      rem_nxt = '0; q_nxt = '0; cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
      neg_nxt = num[COMPONENT_WIDTH-1] ^ negate;
      zn_nxt = (mag == '0);
      zd_nxt = (den == '0);
    end else if (busy_r) begin
      if (trial[DW]) begin
        rem_nxt = {rem_r[DW-1:0], n_r[NW-1]};
        q_nxt = {q_r[NW-2:0], 1'b0};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b1};
      end
      n_nxt = {n_r[NW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; q_r <= q_nxt; cnt_r <= cnt_nxt;
    neg_r <= neg_nxt; zn_r <= zn_nxt; zd_r <= zd_nxt;
  end

  always_comb begin
    if (zn_r)           quo = '0;
    else if (zd_r)      quo = neg_r ? qmin_mag[COMPONENT_WIDTH-1:0] : qmax[COMPONENT_WIDTH-1:0];
    else if (neg_r)     quo = (q_r >= qmin_mag) ? qmin_mag[COMPONENT_WIDTH-1:0]
                                                : COMPONENT_WIDTH'(-$signed({1'b0, q_r}));
    else                quo = (q_r > qmax) ? qmax[COMPONENT_WIDTH-1:0] : q_r[COMPONENT_WIDTH-1:0];
  end
  assign done = done_r;
endmodule

// ----- verif/controller_orientation_recenter_checker.sv -----
// checker for the orientation recenter block: predicts each result word and compares
`timescale 1ns / 1ps

module controller_orientation_recenter_checker import cor_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_cmd,
  input  logic               in_hand,
  input  logic [6:0]         in_buttons,
  input  logic signed [15:0] in_touch_x,
  input  logic signed [15:0] in_touch_y,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_hand,
  input  logic [6:0]         out_button_flags,
  input  logic               out_pad_touched,
  input  logic signed [15:0] out_pad_x,
  input  logic signed [15:0] out_pad_y,
  input  logic signed [15:0] out_orient_w,
  input  logic signed [15:0] out_orient_x,
  input  logic signed [15:0] out_orient_y,
  input  logic signed [15:0] out_orient_z,
  output int                 fail_count,
  output int                 pending_words
);
  localparam int       FRAC = 14;
  localparam longint   COMP_MAX = 32767;
  localparam longint   COMP_MIN = -32768;

  typedef struct packed {
    longint w;
    longint x;
    longint y;
    longint z;
  } quat_t;

  typedef struct packed {
    logic               hand;
    logic [6:0]         flags;
    logic               touched;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } orient_word_t;

  orient_word_t expected_words[$];
  quat_t headset_rot;
  quat_t center_rot[2];
  quat_t zero_rot[2];

  function automatic longint clip(longint v);
    return v > COMP_MAX ? COMP_MAX : (v < COMP_MIN ? COMP_MIN : v);
  endfunction

  // exact sum of four products rounded half up to FRAC bits
  function automatic longint round_sum(longint a, longint b, longint c, longint d);
    longint hi;
    longint lo;
    hi = (a >>> FRAC) + (b >>> FRAC) + (c >>> FRAC) + (d >>> FRAC);
    lo = (a & 16383) + (b & 16383) + (c & 16383) + (d & 16383) + 8192;
    return hi + (lo >>> FRAC);
  endfunction

  function automatic quat_t quat_product(quat_t p, quat_t q);
    quat_t r;
    r.w = clip(round_sum(q.w * p.w, -(q.x * p.x), -(q.y * p.y), -(q.z * p.z)));
    r.x = clip(round_sum(q.w * p.x, q.x * p.w, q.y * p.z, -(q.z * p.y)));
    r.y = clip(round_sum(q.w * p.y, q.y * p.w, q.z * p.x, -(q.x * p.z)));
    r.z = clip(round_sum(q.w * p.z, q.z * p.w, q.x * p.y, -(q.y * p.x)));
    return r;
  endfunction

  function automatic longint sq_norm(quat_t q);
    return round_sum(q.w * q.w, q.x * q.x, q.y * q.y, q.z * q.z);
  endfunction

  // signed quotient, rounded by magnitude, saturating on a zero norm
  function automatic longint fix_div(longint num, longint den, logic negate);
    logic   neg;
    longint mag;
    longint quo;
    neg = (num < 0) != negate;
    mag = num < 0 ? -num : num;
    if (mag == 0) return 0;
    if (den <= 0) return neg ? COMP_MIN : COMP_MAX;
    quo = ((mag <<< FRAC) + (den >>> 1)) / den;
    if (quo > (64'sd1 <<< 40)) quo = 64'sd1 <<< 40;
    return clip(neg ? -quo : quo);
  endfunction

  function automatic quat_t unit_quat();
    quat_t r;
    r = '0;
    r.w = 64'sd1 <<< FRAC;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
    fail_count++;
  endtask

  assign pending_words = expected_words.size();

  always @(posedge clk) begin
    quat_t        raw;
    quat_t        fix;
    quat_t        res;
    longint       dn;
    orient_word_t e;
    if (!rst_n) begin
      headset_rot = unit_quat();
      for (int h = 0; h < 2; h++) begin
        center_rot[h] = unit_quat();
        zero_rot[h] = unit_quat();
      end
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) begin
        raw.w = in_quat_w;
        raw.x = in_quat_x;
        raw.y = in_quat_y;
        raw.z = in_quat_z;
        if (in_cmd == CMD_HEADSET) begin
          headset_rot = raw;
        end else begin
          // recapture center and zero for this hand
          if (in_buttons[BTN_RESET]) begin
            dn = sq_norm(headset_rot);
            center_rot[in_hand].w = fix_div(headset_rot.w, dn, 1'b1);
            center_rot[in_hand].x = fix_div(headset_rot.x, dn, 1'b1);
            center_rot[in_hand].y = fix_div(headset_rot.y, dn, 1'b1);
            center_rot[in_hand].z = fix_div(headset_rot.z, dn, 1'b1);
            dn = sq_norm(raw);
            zero_rot[in_hand].w = fix_div(raw.w, dn, 1'b0);
            zero_rot[in_hand].x = fix_div(raw.x, dn, 1'b1);
            zero_rot[in_hand].y = fix_div(raw.y, dn, 1'b1);
            zero_rot[in_hand].z = fix_div(raw.z, dn, 1'b1);
          end
          // 90 degree fix about x: cos = sin = sqrt(1/2) in Q2.14
          fix = '0;
          fix.w = 11585;
          fix.x = 11585;
          res = quat_product(fix, raw);
          res = quat_product(res, zero_rot[in_hand]);
          res = quat_product(res, center_rot[in_hand]);
          e.hand = in_hand;
          e.flags = in_buttons & BTN_KEEP_MASK;
          e.touched = (in_touch_x != 0) || (in_touch_y != 0);
          e.px = in_touch_x;
          e.py = in_touch_y;
          e.w = res.w[15:0];
          e.x = res.x[15:0];
          e.y = res.y[15:0];
          e.z = res.z[15:0];
          expected_words.insert(expected_words.size(), e);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("[%0t] result word with nothing expected", $time);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          if (out_hand !== e.hand) report("hand", out_hand, e.hand);
          if (out_button_flags !== e.flags) report("button_flags", out_button_flags, e.flags);
          if (out_pad_touched !== e.touched) report("pad_touched", out_pad_touched, e.touched);
          if (out_pad_x !== e.px) report("pad_x", out_pad_x, e.px);
          if (out_pad_y !== e.py) report("pad_y", out_pad_y, e.py);
          if (out_orient_w !== e.w) report("orient_w", out_orient_w, e.w);
          if (out_orient_x !== e.x) report("orient_x", out_orient_x, e.x);
          if (out_orient_y !== e.y) report("orient_y", out_orient_y, e.y);
          if (out_orient_z !== e.z) report("orient_z", out_orient_z, e.z);
        end
      end
    end
  end
endmodule

// ----- verif/controller_orientation_recenter_test.sv -----
// top of the orientation recenter testbench: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module controller_orientation_recenter_test import cor_pkg::*;;
  localparam int RANDOM_WORDS = 1130;
  localparam int CYCLE_LIMIT  = 1500000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_cmd = CMD_HEADSET;
  logic               in_hand = 1'b0;
  logic [6:0]         in_buttons = '0;
  logic signed [15:0] in_touch_x = '0;
  logic signed [15:0] in_touch_y = '0;
  logic signed [15:0] in_quat_w = '0;
  logic signed [15:0] in_quat_x = '0;
  logic signed [15:0] in_quat_y = '0;
  logic signed [15:0] in_quat_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_hand;
  logic [6:0]         out_button_flags;
  logic               out_pad_touched;
  logic signed [15:0] out_pad_x;
  logic signed [15:0] out_pad_y;
  logic signed [15:0] out_orient_w;
  logic signed [15:0] out_orient_x;
  logic signed [15:0] out_orient_y;
  logic signed [15:0] out_orient_z;

  int fail_count;
  int pending_words;
  int cycles = 0;
  int sample_words = 0;
  int headset_words = 0;
  int capture_words = 0;
  int words_sent = 0;
  int words_taken = 0;

  controller_orientation_recenter DUT (.*);

  controller_orientation_recenter_checker scoreboard (.*);

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // quiet stretches: every fourth block of 100 words runs with no idling
  function automatic int draw_wait(int count);
    if ((count / 100) % 4 == 3) return 0;
    return $urandom_range(0, 16);
  endfunction

  // receiver: stalls a random number of cycles before each result word
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(words_taken);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (out_valid) break;
      end
      @(posedge clk);
      words_taken++;
    end
  end

  // drive one word after a gap and hold it until the block takes it
  task automatic send_word(int gap, logic cmd, logic hand, logic [6:0] buttons,
                           logic [15:0] tx, logic [15:0] ty, logic [15:0] qw,
                           logic [15:0] qx, logic [15:0] qy, logic [15:0] qz);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_hand    <= hand;
    in_buttons <= buttons;
    in_touch_x <= tx;
    in_touch_y <= ty;
    in_quat_w  <= qw;
    in_quat_x  <= qx;
    in_quat_y  <= qy;
    in_quat_z  <= qz;
    // in_ready only moves at a rising edge, so the falling edge sees it settled
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    words_sent++;
    if (cmd == CMD_HEADSET) headset_words++;
    else begin
      sample_words++;
      if (buttons[BTN_RESET]) capture_words++;
    end
  endtask

  // one quaternion component: mostly near unit scale, some full range, tiny or extreme
  function automatic logic [15:0] draw_comp(int kind);
    case (kind)
      0: return 16'($signed($urandom_range(0, 32768)) - 16384);
      1: return 16'($urandom);
      2: return 16'($signed($urandom_range(0, 128)) - 64);
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  task automatic send_random(int gap, logic cmd, logic [6:0] buttons);
    int kind;
    int roll;
    logic [15:0] tx;
    logic [15:0] ty;
    roll = $urandom_range(0, 99);
    kind = roll < 70 ? 0 : (roll < 85 ? 1 : (roll < 93 ? 2 : 3));
    // untouched pad now and then
    tx = ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom);
    ty = ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom);
    send_word(gap, cmd, 1'($urandom), buttons, tx, ty, draw_comp(kind), draw_comp(kind),
              draw_comp(kind), draw_comp(kind));
  endtask

  // one edge first so the count of the word just taken has settled
  task automatic wait_drained();
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  localparam logic [6:0] BTN_CAPTURE = 7'h20;

  initial begin
    int   roll;
    logic cmd;
    logic [6:0] buttons;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words
    // plain sample from reset state, identity everywhere
    send_word(0, CMD_SAMPLE, 1'b0, 7'h00, 16'h0000, 16'h0000, 16'h4000, 0, 0, 0);
    // all buttons, touched pad at both extremes
    send_word(0, CMD_SAMPLE, 1'b1, 7'h7f, 16'h7fff, 16'h8000, 16'h4000, 0, 0, 0);
    send_word(3, CMD_SAMPLE, 1'b0, 7'h5f, 16'h8000, 16'h0000, 16'h2d41, 16'h2d41, 0, 0);
    send_word(0, CMD_SAMPLE, 1'b1, 7'h00, 16'h0000, 16'h0001, 16'hd2bf, 0, 16'h2d41, 0);
    // extreme components saturate instead of wrapping
    send_word(0, CMD_SAMPLE, 1'b0, 7'h00, 16'h0001, 16'h0000,
              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(1, CMD_SAMPLE, 1'b1, 7'h00, 16'h0000, 16'h0000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(0, CMD_SAMPLE, 1'b0, 7'h00, 16'hffff, 16'hffff,
              16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    // headset word with the hand bit set is still a headset word
    send_word(0, CMD_HEADSET, 1'b1, 7'h7f, 16'h1234, 16'h5678, 16'h2d41, 0, 16'h2d41, 0);
    send_word(0, CMD_SAMPLE, 1'b0, BTN_CAPTURE, 16'h0100, 16'h0000, 16'h4000, 0, 0, 0);
    send_word(0, CMD_SAMPLE, 1'b0, 7'h10, 16'h0000, 16'h0100, 16'h2d41, 16'h2d41, 0, 0);
    // zero headset quaternion: center components go to zero
    send_word(2, CMD_HEADSET, 1'b0, 7'h00, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(0, CMD_SAMPLE, 1'b1, 7'h7f, 0, 0, 16'h4000, 16'h0010, 0, 0);
    // tiny headset: norm rounds to zero with nonzero numerators
    send_word(0, CMD_HEADSET, 1'b0, 7'h00, 0, 0, 16'h0020, 16'hffe0, 16'h0010, 16'hfff0);
    send_word(0, CMD_SAMPLE, 1'b0, BTN_CAPTURE, 0, 0, 16'h3000, 16'h1000, 16'hf000, 16'h0800);
    // zero and tiny raw quaternion on capture
    send_word(0, CMD_HEADSET, 1'b0, 7'h00, 0, 0, 16'h2000, 16'h2000, 16'h2000, 16'h2000);
    send_word(0, CMD_SAMPLE, 1'b1, BTN_CAPTURE, 0, 0, 0, 0, 0, 0);
    send_word(0, CMD_SAMPLE, 1'b0, BTN_CAPTURE, 0, 0, 16'h0040, 16'hffc0, 0, 16'h0001);
    // extreme raw and headset on capture
    send_word(0, CMD_HEADSET, 1'b0, 7'h00, 0, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_word(0, CMD_SAMPLE, 1'b1, 7'h3f, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_word(0, CMD_SAMPLE, 1'b0, BTN_CAPTURE, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(0, CMD_SAMPLE, 1'b1, 7'h00, 16'h0000, 16'h0000, 16'h4000, 0, 0, 0);
    send_word(0, CMD_SAMPLE, 1'b0, 7'h00, 16'h0000, 16'h0000, 16'h4000, 0, 0, 0);

    // sender holds off until the block has drained
    wait_drained();

    // random words: mostly samples, some headset updates and recaptures
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      roll = $urandom_range(0, 99);
      cmd = roll < 20 ? CMD_HEADSET : CMD_SAMPLE;
      buttons = 7'($urandom);
      buttons[BTN_RESET] = (roll >= 20 && roll < 45);
      send_random(draw_wait(i), cmd, buttons);
      if (i == RANDOM_WORDS / 2) wait_drained();
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (400) @(posedge clk);

    $display("covered %0d sample words (%0d with recapture) and %0d headset words",
             sample_words, capture_words, headset_words);
    $display("%0d result words taken, %0d mismatches", words_taken, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
